FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the smoother RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

FILE: hw/rtl/cds_pkg.sv
// Package for the critically damped smoother: constants and shared types.
`default_nettype none
package cds_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam logic [22:0] SMOOTH_TIME_RST = 23'd19661;
    localparam logic [30:0] MAX_SPEED_RST   = 31'h7FFF_FFFF;
    localparam logic [16:0] STEP_TIME_RST   = 17'd1092;
    localparam logic [1:0] REG_SMOOTH = 2'd0;
    localparam logic [1:0] REG_MAXSPD = 2'd1;
    localparam logic [1:0] REG_STEP   = 2'd2;

    // Multiplier operation codes.
    typedef enum logic [1:0] {
        t_MUL_SIGNED = 2'd0,  // signed Q product, saturated to 32 bits
        t_MUL_UCAP   = 2'd1,  // unsigned Q product, capped at 2^62
        t_MUL_URAW   = 2'd2   // unsigned product shifted, not capped
    } t_mul_op;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647) r = 32'sh7FFF_FFFF;
        else if (v < -34'sd2147483648) r = 32'sh8000_0000;
        else r = v[31:0];
        return r;
    endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/cds_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
`default_nettype none
module cds_div import cds_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [62:0] i_den,
    output logic             o_busy,
    output logic [63:0]      o_quot
);
    logic [63:0] r_q;
    logic [63:0] r_rem;
    logic [6:0]  r_cnt;
    logic [62:0] r_den;
    logic [64:0] w_trial;

    assign w_trial = {r_rem, r_q[63]} - {2'b0, r_den};
    assign o_busy  = (r_cnt != 7'd0);
    assign o_quot  = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 7'd0;
        end else if (i_start) begin
            r_q   <= i_num;
            r_rem <= 64'd0;
            r_den <= i_den;
            r_cnt <= 7'd64;
        end else if (r_cnt != 7'd0) begin
            if (!w_trial[64]) begin
                r_rem <= w_trial[63:0];
                r_q   <= {r_q[62:0], 1'b1};
            end else begin
                r_rem <= {r_rem[62:0], r_q[63]};
                r_q   <= {r_q[62:0], 1'b0};
            end
            r_cnt <= r_cnt - 7'd1;
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/critically_damped_smoother.sv
// Top level of the critically damped smoother.
`default_nettype none
`include "assert_macros.svh"
// Smooth-damp follower in signed Q(32-F).F. One shared 32x32 multiplier, driven by a
// small state machine, runs each word through five products (S_P1 to S_P5); the
// result is registered in S_P5 and S_P6, and o_stall_in stays high until that result
// is taken, so a new word is not accepted before the last result has been taken.
// After reset and after every write to one of the three registers the coefficients
// are recomputed: a divide for omega, the multiplier products (the three wide
// products take two passes each), then a divide for the decay; no word is accepted
// meanwhile. The input is also held off during a register write. The result sits
// in an output register until taken.
module critically_damped_smoother import cds_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               i_valid,
    output logic                    o_stall_in,
    input  wire logic signed [31:0] i_current_value,
    input  wire logic signed [31:0] i_goal_value,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_next_value,
    output logic signed [31:0]      o_next_speed,
    output logic                    o_snapped
);
    localparam logic [63:0] UNIT   = 64'd1 << FRAC_BITS;
    localparam logic [63:0] CAP62  = 64'd1 << 62;
    localparam logic [63:0] LO_RAW = (UNIT + 64'd5000) / 64'd10000;
    localparam logic [63:0] LO     = (LO_RAW == 64'd0) ? 64'd1 : LO_RAW;
    localparam logic [63:0] C048   = (64'd48 * UNIT + 64'd50) / 64'd100;
    localparam logic [63:0] C0235  = (64'd235 * UNIT + 64'd500) / 64'd1000;
    localparam logic [63:0] S32MAX = 64'h7FFF_FFFF;

    typedef enum logic [4:0] {
        S_RST, S_OMW, S_X, S_X2, S_X3, S_T2, S_T3, S_MD, S_DDW, S_IDLE,
        S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_OUT
    } t_state;

    t_state r_state;
    logic [22:0] r_smooth;
    logic [30:0] r_maxspd;
    logic [16:0] r_step;
    logic signed [31:0] r_speed, r_omega, r_decay, r_maxd;
    logic [63:0] r_st, r_x, r_x2, r_x3, r_den;
    logic signed [31:0] r_cur, r_goal, r_dist, r_tgt, r_n7;
    logic r_div_go;
    logic r_ovalid;
    logic [31:0] r_oval, r_ospd;
    logic r_osnap;
    logic r_ph;
    logic [63:0] r_plo;

    // Shared 32x32 multiplier; a product whose second operand is wider than 32 bits
    // takes two passes, the low partial product being held in r_plo.
    t_mul_op w_op;
    logic [31:0] w_a;
    logic [63:0] w_b;
    logic [31:0] w_ua;
    logic [63:0] w_ub;
    logic [31:0] w_mb;
    logic [63:0] w_mp;
    logic [95:0] w_prod;
    logic [63:0] w_sh;
    logic [63:0] w_cap;
    logic signed [31:0] w_smul;
    logic w_neg, w_big, w_two, w_mul_done;

    always_comb begin
        w_op = t_MUL_SIGNED;
        w_a = 32'd0;
        w_b = 64'd0;
        case (r_state)
            S_X:  begin w_op = t_MUL_URAW; w_a = r_omega; w_b = {47'd0, r_step}; end
            S_X2: begin w_op = t_MUL_UCAP; w_a = r_x[31:0]; w_b = r_x;  end
            S_X3: begin w_op = t_MUL_UCAP; w_a = r_x[31:0]; w_b = r_x2; end
            S_T2: begin w_op = t_MUL_UCAP; w_a = C048[31:0]; w_b = r_x2; end
            S_T3: begin w_op = t_MUL_UCAP; w_a = C0235[31:0]; w_b = r_x3; end
            S_MD: begin w_op = t_MUL_URAW; w_a = {1'b0, r_maxspd}; w_b = r_st; end
            S_P1: begin w_a = r_omega; w_b = {{32{r_dist[31]}}, r_dist}; end
            S_P2: begin w_a = r_n7; w_b = {47'd0, r_step}; end
            S_P3: begin w_a = r_omega; w_b = {{32{r_n7[31]}}, r_n7}; end
            S_P4: begin w_a = r_speed; w_b = {{32{r_decay[31]}}, r_decay}; end
            S_P5: begin w_a = r_n7; w_b = {{32{r_decay[31]}}, r_decay}; end
            default: ;
        endcase
    end

    always_comb begin
        w_two = (r_state == S_X3) || (r_state == S_T2) || (r_state == S_T3);
        w_mul_done = !w_two || r_ph;
        w_neg = (w_op == t_MUL_SIGNED) && (w_a[31] != w_b[63]);
        w_ua = (w_op == t_MUL_SIGNED && w_a[31]) ? -w_a : w_a;
        w_ub = (w_op == t_MUL_SIGNED && w_b[63]) ? -w_b : w_b;
        w_mb = r_ph ? w_ub[63:32] : w_ub[31:0];
        w_mp = 64'(w_ua) * 64'(w_mb);
        w_prod = r_ph ? ({w_mp, 32'd0} + {32'd0, r_plo}) : {32'd0, w_mp};
        w_big = (w_prod[95:64] != 32'd0);
        w_sh = 64'(w_prod >> FRAC_BITS);
        w_cap = (w_big || w_sh > CAP62) ? CAP62 : w_sh;
        if (w_sh > S32MAX + 64'd1) w_smul = w_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else if (w_sh == S32MAX + 64'd1) w_smul = w_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else w_smul = w_neg ? -w_sh[31:0] : w_sh[31:0];
    end

    // Shared divider for omega and decay.
    logic w_div_busy;
    logic [63:0] w_quot;
    logic [63:0] w_num;
    logic [62:0] w_dden;
    assign w_num  = (r_state == S_OMW || r_state == S_RST) ? (64'd2 << (2 * FRAC_BITS))
                                                           : (UNIT << FRAC_BITS);
    assign w_dden = (r_state == S_OMW || r_state == S_RST) ? r_st[62:0] : r_den[62:0];

    cds_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_go),
        .i_num(w_num), .i_den(w_dden), .o_busy(w_div_busy), .o_quot(w_quot)
    );

    logic w_cfg_wr, w_in_acc, w_out_acc;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_in_acc  = i_valid && !o_stall_in;
    assign w_out_acc = r_ovalid && !i_stall;
    assign pready = 1'b1;

    always_comb begin
        case (paddr[3:2])
            REG_SMOOTH: prdata = {9'd0, r_smooth};
            REG_MAXSPD: prdata = {1'b0, r_maxspd};
            REG_STEP:   prdata = {15'd0, r_step};
            default:    prdata = 32'd0;
        endcase
    end

    assign o_stall_in = (r_state != S_IDLE) || r_ovalid || w_cfg_wr;

    logic signed [33:0] w_d;
    logic signed [31:0] w_dc, w_nv;
    logic [63:0] w_stf, w_sum;
    logic w_snap;
    always_comb begin
        w_d = 34'(i_current_value) - 34'(i_goal_value);
        if (w_d > 34'(r_maxd)) w_d = 34'(r_maxd);
        if (w_d < -34'(r_maxd)) w_d = -34'(r_maxd);
        w_dc = w_d[31:0];
        w_nv = sat32(34'(r_tgt) + 34'(w_smul));
        w_snap = ((34'(r_goal) - 34'(r_cur)) > 34'sd0) == (w_nv > r_goal);
        w_stf = ({41'd0, r_smooth} < LO) ? LO : {41'd0, r_smooth};
        w_sum = r_den + w_cap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_RST;
            r_smooth <= SMOOTH_TIME_RST;
            r_maxspd <= MAX_SPEED_RST;
            r_step   <= STEP_TIME_RST;
            r_speed  <= 32'sd0;
            r_ovalid <= 1'b0;
            r_div_go <= 1'b0;
            r_st     <= 64'd0;
            r_ph     <= 1'b0;
        end else begin
            r_div_go <= !w_cfg_wr && (r_state == S_RST || r_state == S_MD);
            if (w_out_acc) r_ovalid <= 1'b0;
            if (w_cfg_wr) begin
                r_ph <= 1'b0;
                case (paddr[3:2])
                    REG_SMOOTH: r_smooth <= pwdata[22:0];
                    REG_MAXSPD: r_maxspd <= pwdata[30:0];
                    REG_STEP:   r_step   <= pwdata[16:0];
                    default: ;
                endcase
                if (paddr[3:2] inside {REG_SMOOTH, REG_MAXSPD, REG_STEP}) r_state <= S_RST;
            end else begin
                r_ph <= w_two && !r_ph;
                if (w_two && !r_ph) r_plo <= w_mp;
                case (r_state)
                    S_RST: begin
                        r_st <= w_stf;
                        r_state <= S_OMW;
                    end
                    S_OMW: if (!r_div_go && !w_div_busy) begin
                        r_omega <= (w_quot > S32MAX) ? 32'sh7FFF_FFFF : w_quot[31:0];
                        r_state <= S_X;
                    end
                    S_X: begin
                        r_x <= (w_sh > S32MAX) ? S32MAX : w_sh;
                        r_state <= S_X2;
                    end
                    S_X2: begin r_x2 <= w_cap; r_den <= UNIT + r_x; r_state <= S_X3; end
                    S_X3: if (w_mul_done) begin r_x3 <= w_cap; r_state <= S_T2; end
                    S_T2: if (w_mul_done) begin
                        r_den <= (w_sum > CAP62) ? CAP62 : w_sum;
                        r_state <= S_T3;
                    end
                    S_T3: if (w_mul_done) begin
                        r_den <= (w_sum > CAP62) ? CAP62 : w_sum;
                        r_state <= S_MD;
                    end
                    S_MD: begin
                        r_maxd <= (w_sh > S32MAX) ? 32'sh7FFF_FFFF : w_sh[31:0];
                        r_state <= S_DDW;
                    end
                    S_DDW: if (!r_div_go && !w_div_busy) begin
                        r_decay <= w_quot[31:0];
                        r_state <= S_IDLE;
                    end
                    S_IDLE: if (w_in_acc) begin
                        r_cur <= i_current_value;
                        r_goal <= i_goal_value;
                        r_dist <= w_dc;
                        r_tgt <= sat32(34'(i_current_value) - 34'(w_dc));
                        r_state <= S_P1;
                    end
                    S_P1: begin
                        r_n7 <= sat32(34'(r_speed) + 34'(w_smul));
                        r_state <= S_P2;
                    end
                    S_P2: begin r_n7 <= w_smul; r_state <= S_P3; end
                    S_P3: begin
                        r_speed <= sat32(34'(r_speed) - 34'(w_smul));
                        r_n7 <= sat32(34'(r_dist) + 34'(r_n7));
                        r_state <= S_P4;
                    end
                    S_P4: begin r_speed <= w_smul; r_state <= S_P5; end
                    S_P5: begin
                        r_oval <= w_snap ? r_goal : w_nv;
                        r_osnap <= w_snap;
                        if (w_snap) r_speed <= 32'sd0;
                        r_state <= S_P6;
                    end
                    S_P6: begin
                        r_ospd <= r_speed;
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                    default: r_state <= S_RST;
                endcase
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_next_value = r_oval;
    assign o_next_speed = r_ospd;
    assign o_snapped = r_osnap;

    `ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, o_stall_in)
    `ASSERT_NEXT(a_done_valid, i_clk, i_rst_n, r_state == S_P6 && !w_cfg_wr, o_valid)
    `ASSERT_IMPL(a_snap_speed, i_clk, i_rst_n, o_valid && o_snapped, o_next_speed == 32'sd0)
endmodule
`default_nettype wire
